/* hdl/sita_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_pkg: shared types and constants for the integer-to-ASCII converter
// Holds the radix limits, the character codes and the divider status record.
// ----------------------------------------------------------------------------
package sita_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS       = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO        = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_BIAS  = 8'h37;  // 'A' minus ten
    localparam logic [DIGIT_W-1:0] DIGIT_TEN       = 4'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Map one digit value to its upper-case glyph.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + wide;
        end else begin
            return CHAR_ALPHA_BIAS + wide;
        end
    endfunction

endpackage

/* hdl/sita_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_divider: bit-serial divider by a small radix
// Divides an unsigned value by a base of 2..16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sita_divider
    import sita_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    base,
    output div_status_t           status,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    base_reg, base_next;

    logic [RADIX_W-1:0]    trial;
    logic [RADIX_W-1:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge    = (trial >= base_reg);
    assign diff  = trial - base_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            base_next = base;
        end else if (busy_reg) begin
            // Shift one dividend bit into the partial remainder and subtract.
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

/* hdl/signed_int_to_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_ascii: signed integer to ASCII text in radix 2..16
// Prints a '-' for negative values, then the magnitude, most significant
// digit first, using '0'-'9' and 'A'-'F'.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                  | contents
//  --------+-----------+------------------------+------------------------------
//  s_      | in        | s_tvalid/tready/tdata  | number_in, radix (one number)
//  m_      | out       | m_tvalid/tready/tdata, | ascii_char; m_tlast = last_char
//          |           | m_tlast                | (one transaction per char)
//
//  Each digit costs one full division in the bit-serial divider.
//  s_tready is high only while the sequencer is idle; the last character may
//  still wait in the output register while the next number is taken.
//  Reset: aresetn is synchronous, active low; it clears the sequencer, the
//  divider control and m_tvalid. A stall on m_tready holds the character.
// ----------------------------------------------------------------------------
module signed_int_to_ascii
    import sita_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // [VALUE_BITS-1:0] number_in, [VALUE_BITS+4:VALUE_BITS] radix, zero pad
    input  logic [((VALUE_BITS + RADIX_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // [7:0] ascii_char
    output logic [CHAR_W-1:0]                          m_tdata,
    output logic                                       m_tlast
);

    localparam int DEPTH = VALUE_BITS;             // most digits of one number
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic                neg_reg, neg_next;
    logic [RADIX_W-1:0]  base_reg, base_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    // Digit stack: push the least significant digit first, pop from the top.
    logic [DIGIT_W-1:0]  stack_reg [DEPTH];
    logic                push, pop;

    logic [VALUE_BITS-1:0] in_number;
    logic [RADIX_W-1:0]    in_radix;
    logic [RADIX_W-1:0]    in_base;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_accept;
    logic                  out_free;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [RADIX_W-1:0]    div_base;
    div_status_t           div_status;
    logic [VALUE_BITS-1:0] div_quo;
    logic [DIGIT_W-1:0]    div_rem;

    // Unpack the input transaction and form the unsigned magnitude.
    assign in_number = s_tdata[VALUE_BITS-1:0];
    assign in_radix  = s_tdata[VALUE_BITS +: RADIX_W];
    assign in_mag    = in_number[VALUE_BITS-1] ? ({VALUE_BITS{1'b0}} - in_number)
                                               : in_number;

    always_comb begin
        if (in_radix < RADIX_MIN) begin
            in_base = RADIX_MIN;
        end else if (in_radix > RADIX_MAX) begin
            in_base = RADIX_MAX;
        end else begin
            in_base = in_radix;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    sita_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .base      (div_base),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer: divide until the quotient is zero, then print sign and digits.
    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        neg_next      = neg_reg;
        base_next     = base_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        push          = 1'b0;
        pop           = 1'b0;
        div_start     = 1'b0;
        div_dividend  = div_quo;
        div_base      = base_reg;

        case (state_reg)
            ST_IDLE: begin
                div_dividend = in_mag;
                div_base     = in_base;
                if (in_accept) begin
                    div_start  = 1'b1;
                    neg_next   = in_number[VALUE_BITS-1];
                    base_next  = in_base;
                    depth_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    push       = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    if (div_quo != '0) begin
                        div_start = 1'b1;
                    end else if (neg_reg) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CHAR_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    pop           = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = digit_glyph(stack_reg[0]);
                    m_tlast_next  = (depth_reg == CNT_W'(1));
                    depth_next    = depth_reg - 1'b1;
                    if (depth_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        neg_reg     <= neg_next;
        base_reg    <= base_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Push shifts every digit one place deeper; pop shifts them back up.
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[0] <= div_rem;
            for (int i = 1; i < DEPTH; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The divider reports a result only while the sequencer waits for one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    // A new number is never taken while the divider is still working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_status.busy)
        else $error("input ready while divider busy");

    // The digit stack never overflows its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CNT_W'(DEPTH))
        else $error("digit stack overflow");

    // Every digit emitted comes from a non-empty stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (depth_reg != '0))
        else $error("pop from empty digit stack");

endmodule
